### hdl/kbdf_pkg.sv
// kbdf_pkg: shared types, constants and helpers for the keyboard byte demux fifo
`default_nettype none
package kbdf_pkg;

  // fifo sizes and derived widths
  localparam int RAW_DEPTH  = 64;
  localparam int KEY_DEPTH  = 16;
  localparam int CMDQ_DEPTH = 2;
  localparam int RAW_AW     = $clog2(RAW_DEPTH);
  localparam int KEY_AW     = $clog2(KEY_DEPTH);
  localparam int CQ_AW      = $clog2(CMDQ_DEPTH);
  localparam int CQ_CW      = $clog2(CMDQ_DEPTH + 1);
  localparam int COUNT_W    = 8;

  // operation codes on in_op
  localparam logic [1:0] OP_SAMPLE = 2'd0;
  localparam logic [1:0] OP_PUMP   = 2'd1;
  localparam logic [1:0] OP_POP    = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_WINDOW_MASK  = 2'd0;
  localparam logic [1:0] CFG_WINDOW_VALUE = 2'd1;
  localparam logic [1:0] CFG_ESC_AUTO     = 2'd2;
  localparam logic [1:0] CFG_ESC_TIMEOUT  = 2'd3;

  // register reset values
  localparam logic [15:0] WINDOW_MASK_RST  = 16'hFF00;
  localparam logic [15:0] WINDOW_VALUE_RST = 16'h0000;
  localparam logic        ESC_AUTO_RST     = 1'b1;
  localparam logic [31:0] ESC_TIMEOUT_RST  = 32'd200000;

  // byte classes
  localparam logic [6:0] ESC_CODE     = 7'h01;
  localparam logic [7:0] RELEASE_BASE = 8'h80;
  localparam logic [7:0] HEADER_BASE  = 8'hF2;

  typedef enum logic [1:0] {
    CMD_STATUS,
    CMD_PUSH,
    CMD_PUMP,
    CMD_POP
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [7:0]  data;
    logic [31:0] now;
  } cmd_t;

  typedef struct packed {
    logic        we;
    logic [1:0]  index;
    logic [31:0] wdata;
  } cfg_wr_t;

  function automatic logic [RAW_AW-1:0] raw_adv(input logic [RAW_AW-1:0] p);
    return (p == RAW_AW'(RAW_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [KEY_AW-1:0] key_adv(input logic [KEY_AW-1:0] p);
    return (p == KEY_AW'(KEY_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [COUNT_W-1:0] raw_cnt(input logic [RAW_AW-1:0] h,
                                                 input logic [RAW_AW-1:0] t);
    logic [RAW_AW:0] d;
    if (h >= t) begin
      d = {1'b0, h} - {1'b0, t};
    end else begin
      d = {1'b0, h} + (RAW_AW + 1)'(RAW_DEPTH) - {1'b0, t};
    end
    return COUNT_W'(d);
  endfunction

endpackage
`default_nettype wire

### hdl/kbdf_front.sv
// kbdf_front: accepts input words, holds the address window and classifies each word
`default_nettype none
module kbdf_front (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire kbdf_pkg::cfg_wr_t cfg,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire logic [1:0]     in_op,
  input  wire logic [15:0]    in_addr_sample,
  input  wire logic [31:0]    in_now_us,
  output logic                q_push,
  output kbdf_pkg::cmd_t      q_cmd,
  input  wire logic           q_full
);
  import kbdf_pkg::*;

  logic [15:0] window_mask_r;
  logic [15:0] window_value_r;
  logic        hit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_mask_r  <= WINDOW_MASK_RST;
      window_value_r <= WINDOW_VALUE_RST;
    end else if (cfg.we) begin
      if (cfg.index == CFG_WINDOW_MASK)  window_mask_r  <= cfg.wdata[15:0];
      if (cfg.index == CFG_WINDOW_VALUE) window_value_r <= cfg.wdata[15:0];
    end
  end

  assign hit = (in_addr_sample & window_mask_r) == window_value_r;

  always_comb begin
    q_cmd.data = in_addr_sample[7:0];
    q_cmd.now  = in_now_us;
    unique case (in_op)
      OP_SAMPLE: q_cmd.kind = hit ? CMD_PUSH : CMD_STATUS;
      OP_PUMP:   q_cmd.kind = CMD_PUMP;
      OP_POP:    q_cmd.kind = CMD_POP;
      default:   q_cmd.kind = CMD_STATUS;
    endcase
  end

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

endmodule
`default_nettype wire

### hdl/kbdf_cmdq.sv
// kbdf_cmdq: short command queue between the front and back parts
`default_nettype none
module kbdf_cmdq (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire kbdf_pkg::cmd_t push_cmd,
  output logic                full,
  input  wire logic           pop,
  output logic                valid,
  output kbdf_pkg::cmd_t      head_cmd
);
  import kbdf_pkg::*;

  cmd_t             q_mem [CMDQ_DEPTH];
  logic [CQ_AW-1:0] wr_ptr_r;
  logic [CQ_AW-1:0] rd_ptr_r;
  logic [CQ_CW-1:0] count_r;
  logic             do_push;
  logic             do_pop;

  assign full     = count_r == CQ_CW'(CMDQ_DEPTH);
  assign valid    = count_r != '0;
  assign head_cmd = q_mem[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && valid;

  always_ff @(posedge clk) begin
    if (do_push) q_mem[wr_ptr_r] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == CQ_AW'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == CQ_AW'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

### hdl/kbdf_back.sv
// kbdf_back: executes commands on the raw and key fifos and drives the result word
`default_nettype none
module kbdf_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire kbdf_pkg::cfg_wr_t cfg,
  input  wire logic           q_valid,
  input  wire kbdf_pkg::cmd_t q_cmd,
  output logic                q_pop,
  output logic                out_valid,
  input  wire logic           out_stall,
  output logic                out_key_valid,
  output logic [6:0]          out_key_scancode,
  output logic                out_key_press,
  output logic                out_exit_request,
  output logic                out_sample_dropped,
  output logic [7:0]          out_raw_count,
  output logic [31:0]         out_dropped_count
);
  import kbdf_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_PUMP_RD,
    S_PUMP_PROC
  } state_t;

  state_t state_r;

  logic              esc_auto_r;
  logic [31:0]       esc_timeout_r;

  logic [7:0]        raw_mem [RAW_DEPTH];
  logic [7:0]        raw_rd_r;
  logic [RAW_AW-1:0] raw_head_r;
  logic [RAW_AW-1:0] raw_tail_r;
  logic [31:0]       drop_cnt_r;

  logic [7:0]        key_mem [KEY_DEPTH];
  logic [KEY_AW-1:0] key_head_r;
  logic [KEY_AW-1:0] key_tail_r;

  logic [31:0]       esc_time_r;
  logic [31:0]       now_r;
  logic              exit_acc_r;

  logic              out_valid_r;
  logic              out_key_valid_r;
  logic [6:0]        out_code_r;
  logic              out_press_r;
  logic              out_exit_r;
  logic              out_drop_r;
  logic [COUNT_W-1:0] out_count_r;
  logic [31:0]       out_dcnt_r;

  logic              free;
  logic              take;
  logic              out_load;
  logic [RAW_AW-1:0] raw_hd_nxt;
  logic              raw_full;
  logic              raw_wr_en;
  logic              raw_rd_en;
  logic              ev_press;
  logic              ev_release;
  logic [6:0]        ev_code;
  logic              ev_valid;
  logic [KEY_AW-1:0] key_hd_nxt;
  logic              key_full;
  logic              key_wr_en;
  logic              key_empty;
  logic [7:0]        key_rd;
  logic [31:0]       elapsed;
  logic              esc_ev;
  logic              esc_hit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      esc_auto_r    <= ESC_AUTO_RST;
      esc_timeout_r <= ESC_TIMEOUT_RST;
    end else if (cfg.we) begin
      if (cfg.index == CFG_ESC_AUTO)    esc_auto_r    <= cfg.wdata[0];
      if (cfg.index == CFG_ESC_TIMEOUT) esc_timeout_r <= cfg.wdata;
    end
  end

  assign free       = !out_valid_r || !out_stall;
  assign take       = (state_r == S_IDLE) && q_valid && free;
  assign q_pop      = take;

  assign raw_hd_nxt = raw_adv(raw_head_r);
  assign raw_full   = raw_hd_nxt == raw_tail_r;
  assign raw_wr_en  = take && (q_cmd.kind == CMD_PUSH) && !raw_full;
  assign raw_rd_en  = (state_r == S_PUMP_RD) && (raw_tail_r != raw_head_r);

  // a result word is loaded on a non-pump command or when a pump finds the raw fifo empty
  assign out_load   = (take && (q_cmd.kind != CMD_PUMP))
                      || ((state_r == S_PUMP_RD) && !raw_rd_en && free);

  // decode of the byte read back from the raw fifo
  assign ev_press   = raw_rd_r < RELEASE_BASE;
  assign ev_release = !ev_press && (raw_rd_r < HEADER_BASE);
  assign ev_code    = raw_rd_r[6:0];
  assign ev_valid   = (state_r == S_PUMP_PROC) && (ev_press || ev_release) && (ev_code != '0);

  assign key_hd_nxt = key_adv(key_head_r);
  assign key_full   = key_hd_nxt == key_tail_r;
  assign key_wr_en  = ev_valid && !key_full;
  assign key_empty  = key_head_r == key_tail_r;
  assign key_rd     = key_mem[key_tail_r];

  // modular elapsed time since the pending escape press
  assign elapsed    = now_r - esc_time_r;
  assign esc_ev     = ev_valid && (ev_code == ESC_CODE);
  assign esc_hit    = esc_ev && ev_release && esc_auto_r && (esc_time_r != '0)
                      && (elapsed < esc_timeout_r);

  always_ff @(posedge clk) begin
    if (raw_wr_en) raw_mem[raw_head_r] <= q_cmd.data;
    if (raw_rd_en) raw_rd_r <= raw_mem[raw_tail_r];
  end

  always_ff @(posedge clk) begin
    if (key_wr_en) key_mem[key_head_r] <= {ev_press, ev_code};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      raw_head_r  <= '0;
      raw_tail_r  <= '0;
      drop_cnt_r  <= '0;
      key_head_r  <= '0;
      key_tail_r  <= '0;
      esc_time_r  <= '0;
      exit_acc_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (take) begin
            unique case (q_cmd.kind)
              CMD_STATUS: begin
                out_key_valid_r <= 1'b0;
                out_code_r      <= '0;
                out_press_r     <= 1'b0;
                out_exit_r      <= 1'b0;
                out_drop_r      <= 1'b0;
                out_count_r     <= raw_cnt(raw_head_r, raw_tail_r);
                out_dcnt_r      <= drop_cnt_r;
              end
              CMD_PUSH: begin
                out_key_valid_r <= 1'b0;
                out_code_r      <= '0;
                out_press_r     <= 1'b0;
                out_exit_r      <= 1'b0;
                out_drop_r      <= raw_full;
                if (raw_full) begin
                  drop_cnt_r  <= drop_cnt_r + 1'b1;
                  out_dcnt_r  <= drop_cnt_r + 1'b1;
                  out_count_r <= raw_cnt(raw_head_r, raw_tail_r);
                end else begin
                  raw_head_r  <= raw_hd_nxt;
                  out_dcnt_r  <= drop_cnt_r;
                  out_count_r <= raw_cnt(raw_hd_nxt, raw_tail_r);
                end
              end
              CMD_POP: begin
                if (!key_empty) key_tail_r <= key_adv(key_tail_r);
                out_key_valid_r <= !key_empty;
                out_code_r      <= key_empty ? 7'd0 : key_rd[6:0];
                out_press_r     <= !key_empty && key_rd[7];
                out_exit_r      <= 1'b0;
                out_drop_r      <= 1'b0;
                out_count_r     <= raw_cnt(raw_head_r, raw_tail_r);
                out_dcnt_r      <= drop_cnt_r;
              end
              CMD_PUMP: begin
                now_r      <= q_cmd.now;
                exit_acc_r <= 1'b0;
                state_r    <= S_PUMP_RD;
              end
              default: ;
            endcase
          end
        end
        S_PUMP_RD: begin
          if (raw_rd_en) begin
            raw_tail_r <= raw_adv(raw_tail_r);
            state_r    <= S_PUMP_PROC;
          end else if (free) begin
            out_key_valid_r <= 1'b0;
            out_code_r      <= '0;
            out_press_r     <= 1'b0;
            out_exit_r      <= exit_acc_r;
            out_drop_r      <= 1'b0;
            out_count_r     <= raw_cnt(raw_head_r, raw_tail_r);
            out_dcnt_r      <= drop_cnt_r;
            state_r         <= S_IDLE;
          end
        end
        S_PUMP_PROC: begin
          if (key_wr_en) key_head_r <= key_hd_nxt;
          if (esc_ev) begin
            // a press at time zero is kept as one so it stays pending
            if (ev_press) begin
              esc_time_r <= (now_r == '0) ? 32'd1 : now_r;
            end else begin
              esc_time_r <= '0;
            end
          end
          if (esc_hit) exit_acc_r <= 1'b1;
          state_r <= S_PUMP_RD;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid          = out_valid_r;
  assign out_key_valid      = out_key_valid_r;
  assign out_key_scancode   = out_code_r;
  assign out_key_press      = out_press_r;
  assign out_exit_request   = out_exit_r;
  assign out_sample_dropped = out_drop_r;
  assign out_raw_count      = out_count_r;
  assign out_dropped_count  = out_dcnt_r;

endmodule
`default_nettype wire

### hdl/keyboard_byte_demux_fifo_core.sv
// keyboard_byte_demux_fifo_core: top level of the keyboard byte demux with raw and key fifos
//
// Each input word carries one operation (bus sample, pump, pop, or no operation) and
// yields exactly one result word, in order. The front classifies words against the
// address window and takes one word per cycle while its two-entry command queue has
// room; the back executes them. A sample, pop or no-operation word is handled in the
// back's idle state, so those run at one word per cycle while no pump is busy and the
// result is not stalled. A pump takes one back step to take it, a read and a decode step
// per byte drained, because each byte goes through the registered read port
// of the raw byte memory before it is decoded into the key fifo, and one more to find
// the fifo empty. Both byte stores start undefined and need no clearing pass after reset.
// Configuration writes are taken at any cycle but must only be issued while idle.
`default_nettype none
module keyboard_byte_demux_fifo_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_op,
  input  wire logic [15:0] in_addr_sample,
  input  wire logic [31:0] in_now_us,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_key_valid,
  output logic [6:0]       out_key_scancode,
  output logic             out_key_press,
  output logic             out_exit_request,
  output logic             out_sample_dropped,
  output logic [7:0]       out_raw_count,
  output logic [31:0]      out_dropped_count
);
  import kbdf_pkg::*;

  cfg_wr_t cfg;
  logic    q_push;
  cmd_t    q_push_cmd;
  logic    q_full;
  logic    q_pop;
  logic    q_valid;
  cmd_t    q_head_cmd;

  assign cfg.we    = cfg_we;
  assign cfg.index = cfg_index;
  assign cfg.wdata = cfg_wdata;

  kbdf_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_op          (in_op),
    .in_addr_sample (in_addr_sample),
    .in_now_us      (in_now_us),
    .q_push         (q_push),
    .q_cmd          (q_push_cmd),
    .q_full         (q_full)
  );

  kbdf_cmdq u_cmdq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .valid    (q_valid),
    .head_cmd (q_head_cmd)
  );

  kbdf_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg                (cfg),
    .q_valid            (q_valid),
    .q_cmd              (q_head_cmd),
    .q_pop              (q_pop),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_key_valid      (out_key_valid),
    .out_key_scancode   (out_key_scancode),
    .out_key_press      (out_key_press),
    .out_exit_request   (out_exit_request),
    .out_sample_dropped (out_sample_dropped),
    .out_raw_count      (out_raw_count),
    .out_dropped_count  (out_dropped_count)
  );

endmodule
`default_nettype wire

### hdl/kbdf_checker.sv
// kbdf_checker: port-level checks of the result channel, bound to the top level
`default_nettype none
module kbdf_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic        out_key_valid,
  input wire logic [6:0]  out_key_scancode,
  input wire logic        out_key_press,
  input wire logic        out_exit_request,
  input wire logic        out_sample_dropped,
  input wire logic [7:0]  out_raw_count,
  input wire logic [31:0] out_dropped_count
);
  import kbdf_pkg::*;

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_key_valid)
      && $stable(out_key_scancode) && $stable(out_key_press)
      && $stable(out_exit_request) && $stable(out_sample_dropped)
      && $stable(out_raw_count) && $stable(out_dropped_count))
    else $error("result word changed while stalled");

  // a popped event word carries no pump or sample status
  a_one_op: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_key_valid |-> !out_exit_request && !out_sample_dropped)
    else $error("pop result carries pump or sample status");

  // a drop only happens with the raw fifo at capacity
  a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_sample_dropped |-> out_raw_count == COUNT_W'(RAW_DEPTH - 1))
    else $error("sample dropped while raw fifo not full");

  // an exit request comes from a pump, which leaves the raw fifo empty
  a_exit_drained: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_exit_request |-> out_raw_count == '0)
    else $error("exit request with bytes left in raw fifo");

  // no event fields without a popped event
  a_no_event: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_key_valid |-> out_key_scancode == '0 && !out_key_press)
    else $error("event fields set without a popped event");

endmodule

bind keyboard_byte_demux_fifo_core kbdf_checker u_kbdf_checker (.*);
`default_nettype wire
